[sv/sp4ct_pkg.sv]
`timescale 1ns / 1ps
package sp4ct_pkg;

  localparam int unsigned SlotBits  = 16;
  localparam int unsigned BlockBits = 64;
  localparam int unsigned CharBase  = 4 * BlockBits;
  localparam int unsigned InBits    = 264;
  localparam int unsigned OutBits   = 8;

  localparam logic [2:0] ExpZero     = 3'd0;
  localparam logic [2:0] ExpHalfTurn = 3'd4;

  // characteristic parities and input check, carried alongside the products
  typedef struct packed {
    logic bad;
    logic nu0;
    logic nu1;
    logic nl0;
    logic nl1;
    logic q1;
  } chr_t;

endpackage

[sv/sp4ct_prod.sv]
`timescale 1ns / 1ps
module sp4ct_prod #(
  parameter int unsigned ENTRY_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [sp4ct_pkg::InBits-1:0]           data_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic signed [2*ENTRY_BITS-1:0]         sym_o [8],
  output logic signed [2*ENTRY_BITS-1:0]         adcb_o [16],
  output sp4ct_pkg::chr_t                        chr_o
);
  import sp4ct_pkg::*;

  localparam int unsigned ProdBits = 2 * ENTRY_BITS;

  logic signed [ENTRY_BITS-1:0] a [4];
  logic signed [ENTRY_BITS-1:0] b [4];
  logic signed [ENTRY_BITS-1:0] c [4];
  logic signed [ENTRY_BITS-1:0] d [4];
  logic signed [ProdBits-1:0]   sym_d [8];
  logic signed [ProdBits-1:0]   adcb_d [16];
  logic signed [ProdBits-1:0]   sym_q [8];
  logic signed [ProdBits-1:0]   adcb_q [16];
  logic [1:0]                   uf1, uf2, lf1, lf2;
  logic                         u0, u1, l0, l1;
  logic                         m00, m01, m10, m11;
  chr_t                         chr_d, chr_q;
  logic                         valid_q;

  function automatic logic signed [ProdBits-1:0] mul(
    input logic signed [ENTRY_BITS-1:0] x,
    input logic signed [ENTRY_BITS-1:0] y
  );
    return ProdBits'(x) * ProdBits'(y);
  endfunction

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a[k] = data_i[k*SlotBits +: ENTRY_BITS];
      b[k] = data_i[BlockBits + k*SlotBits +: ENTRY_BITS];
      c[k] = data_i[2*BlockBits + k*SlotBits +: ENTRY_BITS];
      d[k] = data_i[3*BlockBits + k*SlotBits +: ENTRY_BITS];
    end
  end

  // off-diagonal terms of a^t c and b^t d
  always_comb begin
    sym_d[0] = mul(a[0], c[1]);
    sym_d[1] = mul(a[2], c[3]);
    sym_d[2] = mul(a[1], c[0]);
    sym_d[3] = mul(a[3], c[2]);
    sym_d[4] = mul(b[0], d[1]);
    sym_d[5] = mul(b[2], d[3]);
    sym_d[6] = mul(b[1], d[0]);
    sym_d[7] = mul(b[3], d[2]);
  end

  // terms of a^t d - c^t b
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        adcb_d[(i*2+j)*4]     = mul(a[i],     d[j]);
        adcb_d[(i*2+j)*4 + 1] = mul(a[2 + i], d[2 + j]);
        adcb_d[(i*2+j)*4 + 2] = mul(c[i],     b[j]);
        adcb_d[(i*2+j)*4 + 3] = mul(c[2 + i], b[2 + j]);
      end
    end
  end

  assign uf1 = data_i[CharBase +: 2];
  assign uf2 = data_i[CharBase + 2 +: 2];
  assign lf1 = data_i[CharBase + 4 +: 2];
  assign lf2 = data_i[CharBase + 6 +: 2];
  assign u0  = uf1[0];
  assign u1  = uf2[0];
  assign l0  = lf1[0];
  assign l1  = lf2[0];

  // parities of b d^t
  assign m00 = (b[0][0] & d[0][0]) ^ (b[1][0] & d[1][0]);
  assign m01 = (b[0][0] & d[2][0]) ^ (b[1][0] & d[3][0]);
  assign m10 = (b[2][0] & d[0][0]) ^ (b[3][0] & d[1][0]);
  assign m11 = (b[2][0] & d[2][0]) ^ (b[3][0] & d[3][0]);

  always_comb begin
    chr_d.bad = uf1[1] | uf2[1] | lf1[1] | lf2[1];
    chr_d.nu0 = (d[0][0] & u0) ^ (d[1][0] & u1) ^ (c[0][0] & l0) ^ (c[1][0] & l1)
              ^ (c[0][0] & d[0][0]) ^ (c[1][0] & d[1][0]);
    chr_d.nu1 = (d[2][0] & u0) ^ (d[3][0] & u1) ^ (c[2][0] & l0) ^ (c[3][0] & l1)
              ^ (c[2][0] & d[2][0]) ^ (c[3][0] & d[3][0]);
    chr_d.nl0 = (a[0][0] & l0) ^ (a[1][0] & l1) ^ (b[0][0] & u0) ^ (b[1][0] & u1)
              ^ (a[0][0] & b[0][0]) ^ (a[1][0] & b[1][0]);
    chr_d.nl1 = (a[2][0] & l0) ^ (a[3][0] & l1) ^ (b[2][0] & u0) ^ (b[3][0] & u1)
              ^ (a[2][0] & b[2][0]) ^ (a[3][0] & b[3][0]);
    chr_d.q1  = (u0 & m00) ^ (u0 & u1 & (m01 ^ m10)) ^ (u1 & m11);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sym_q  <= sym_d;
      adcb_q <= adcb_d;
      chr_q  <= chr_d;
    end
  end

  assign valid_o = valid_q;
  assign sym_o   = sym_q;
  assign adcb_o  = adcb_q;
  assign chr_o   = chr_q;

endmodule

[sv/sp4ct_sum.sv]
`timescale 1ns / 1ps
module sp4ct_sum #(
  parameter int unsigned ENTRY_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [2*ENTRY_BITS-1:0]    sym_i [8],
  input  logic signed [2*ENTRY_BITS-1:0]    adcb_i [16],
  input  sp4ct_pkg::chr_t                   chr_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [2*ENTRY_BITS+1:0]    sym_o [2],
  output logic signed [2*ENTRY_BITS+1:0]    adcb_o [4],
  output sp4ct_pkg::chr_t                   chr_o
);
  import sp4ct_pkg::*;

  localparam int unsigned SumBits = 2 * ENTRY_BITS + 2;

  logic signed [SumBits-1:0] sym_d [2];
  logic signed [SumBits-1:0] adcb_d [4];
  logic signed [SumBits-1:0] sym_q [2];
  logic signed [SumBits-1:0] adcb_q [4];
  chr_t                      chr_q;
  logic                      valid_q;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sym_d[k] = SumBits'(sym_i[4*k]) + SumBits'(sym_i[4*k + 1])
               - SumBits'(sym_i[4*k + 2]) - SumBits'(sym_i[4*k + 3]);
    end
    for (int k = 0; k < 4; k++) begin
      adcb_d[k] = SumBits'(adcb_i[4*k]) + SumBits'(adcb_i[4*k + 1])
                - SumBits'(adcb_i[4*k + 2]) - SumBits'(adcb_i[4*k + 3]);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sym_q  <= sym_d;
      adcb_q <= adcb_d;
      chr_q  <= chr_i;
    end
  end

  assign valid_o = valid_q;
  assign sym_o   = sym_q;
  assign adcb_o  = adcb_q;
  assign chr_o   = chr_q;

endmodule

[sv/sp4ct_res.sv]
`timescale 1ns / 1ps
module sp4ct_res #(
  parameter int unsigned ENTRY_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [2*ENTRY_BITS+1:0]    sym_i [2],
  input  logic signed [2*ENTRY_BITS+1:0]    adcb_i [4],
  input  sp4ct_pkg::chr_t                   chr_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [sp4ct_pkg::OutBits-1:0]     data_o
);
  import sp4ct_pkg::*;

  localparam int unsigned SumBits = 2 * ENTRY_BITS + 2;

  logic                 ok;
  logic [2:0]           exp_d;
  logic [OutBits-1:0]   data_d, data_q;
  logic                 valid_q;

  assign ok = !chr_i.bad
           && (sym_i[0] == SumBits'(0)) && (sym_i[1] == SumBits'(0))
           && (adcb_i[0] == SumBits'(1)) && (adcb_i[1] == SumBits'(0))
           && (adcb_i[2] == SumBits'(0)) && (adcb_i[3] == SumBits'(1));

  assign exp_d  = (ok && chr_i.q1) ? ExpHalfTurn : ExpZero;
  assign data_d = {exp_d, ok & chr_i.nl1, ok & chr_i.nl0, ok & chr_i.nu1, ok & chr_i.nu0, !ok};

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/sp4_characteristic_transform_top.sv]
`timescale 1ns / 1ps
// channel   port group   tdata fields, lowest bit first
// in        s_axis       block_a[63:0] block_b[127:64] block_c[191:128] block_d[255:192]
//                        upper_bit_one[257:256] upper_bit_two[259:258]
//                        lower_bit_one[261:260] lower_bit_two[263:262]
// out       m_axis       status[0] new_upper_one[1] new_upper_two[2] new_lower_one[3]
//                        new_lower_two[4] multiplier_exponent[7:5]
//
// one transfer per cycle in and out while m_axis_tready is high
// stages: entry products, product sums, symplectic check and output register
// rst_ni clears the stage valid bits only
// each stage holds while the next is full and stalled, so s_axis_tready falls only
// when all three stages are full and m_axis_tready is low
module sp4_characteristic_transform_top #(
  parameter int unsigned ENTRY_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // block_a, block_b, block_c, block_d, upper_bit_one, upper_bit_two,
  // lower_bit_one, lower_bit_two
  input  logic [sp4ct_pkg::InBits-1:0]    s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // status, new_upper_one, new_upper_two, new_lower_one, new_lower_two,
  // multiplier_exponent
  output logic [sp4ct_pkg::OutBits-1:0]   m_axis_tdata_o
);
  import sp4ct_pkg::*;

  localparam int unsigned ProdBits = 2 * ENTRY_BITS;
  localparam int unsigned SumBits  = 2 * ENTRY_BITS + 2;

  logic                       p_valid, p_ready, s_valid, s_ready;
  logic signed [ProdBits-1:0] p_sym [8];
  logic signed [ProdBits-1:0] p_adcb [16];
  logic signed [SumBits-1:0]  s_sym [2];
  logic signed [SumBits-1:0]  s_adcb [4];
  chr_t                       p_chr, s_chr;

  sp4ct_prod #(.ENTRY_BITS(ENTRY_BITS)) u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .valid_o (p_valid),
    .ready_i (p_ready),
    .sym_o   (p_sym),
    .adcb_o  (p_adcb),
    .chr_o   (p_chr)
  );

  sp4ct_sum #(.ENTRY_BITS(ENTRY_BITS)) u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_valid),
    .ready_o (p_ready),
    .sym_i   (p_sym),
    .adcb_i  (p_adcb),
    .chr_i   (p_chr),
    .valid_o (s_valid),
    .ready_i (s_ready),
    .sym_o   (s_sym),
    .adcb_o  (s_adcb),
    .chr_o   (s_chr)
  );

  sp4ct_res #(.ENTRY_BITS(ENTRY_BITS)) u_res (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .ready_o (s_ready),
    .sym_i   (s_sym),
    .adcb_i  (s_adcb),
    .chr_i   (s_chr),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o)
  );

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |-> (m_axis_tdata_o[7:1] == 7'd0))
    else $error("error result carries nonzero fields");

  a_exp_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[6:5] == 2'd0))
    else $error("phase exponent not a multiple of four");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (p_valid && s_valid && m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled while the pipeline has room");

  a_bubble_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid && !m_axis_tvalid_o) |=> m_axis_tvalid_o)
    else $error("result stage did not take a pending item");
`endif

endmodule

[tb/sp4_transform_checker.sv]
`timescale 1ns / 1ps
module sp4_transform_checker #(
  parameter int unsigned ENTRY_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [sp4ct_pkg::InBits-1:0]  s_axis_tdata_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic [sp4ct_pkg::OutBits-1:0] m_axis_tdata_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  typedef struct packed {
    logic [1:0]  lower_two;
    logic [1:0]  lower_one;
    logic [1:0]  upper_two;
    logic [1:0]  upper_one;
    logic [63:0] blk_d;
    logic [63:0] blk_c;
    logic [63:0] blk_b;
    logic [63:0] blk_a;
  } xform_item_t;

  typedef struct packed {
    logic [2:0] exponent;
    logic       new_lower_two;
    logic       new_lower_one;
    logic       new_upper_two;
    logic       new_upper_one;
    logic       status;
  } xform_result_t;

  xform_result_t expected_q[$];
  xform_result_t want;
  xform_result_t got;
  int            errors = 0;

  function automatic longint slot_value(input logic [63:0] blk, input int pos);
    logic [15:0] slot;
    longint      v;
    longint      span;
    slot = blk[16*pos +: 16];
    span = longint'(1) << ENTRY_BITS;
    v    = longint'(slot) & (span - 1);
    if (v >= (span >> 1)) begin
      v = v - span;
    end
    return v;
  endfunction

  function automatic xform_result_t predict_transform(input xform_item_t it);
    xform_result_t r;
    longint a00, a01, a10, a11, b00, b01, b10, b11;
    longint c00, c01, c10, c11, d00, d01, d10, d11;
    longint u0, u1, l0, l1;
    longint du0, du1, cl0, cl1, ab0, ab1, nu0, nu1, nl0, nl1;
    longint bd00, bd01, bd10, bd11, ac00, ac01, ac10, ac11;
    longint bc00, bc01, bc10, bc11, q1, q2, q3, ph;
    bit     ok;
    r   = '0;
    a00 = slot_value(it.blk_a, 0);
    a01 = slot_value(it.blk_a, 1);
    a10 = slot_value(it.blk_a, 2);
    a11 = slot_value(it.blk_a, 3);
    b00 = slot_value(it.blk_b, 0);
    b01 = slot_value(it.blk_b, 1);
    b10 = slot_value(it.blk_b, 2);
    b11 = slot_value(it.blk_b, 3);
    c00 = slot_value(it.blk_c, 0);
    c01 = slot_value(it.blk_c, 1);
    c10 = slot_value(it.blk_c, 2);
    c11 = slot_value(it.blk_c, 3);
    d00 = slot_value(it.blk_d, 0);
    d01 = slot_value(it.blk_d, 1);
    d10 = slot_value(it.blk_d, 2);
    d11 = slot_value(it.blk_d, 3);

    ok = (it.upper_one <= 2'd1) && (it.upper_two <= 2'd1) &&
         (it.lower_one <= 2'd1) && (it.lower_two <= 2'd1);
    // A^T C and B^T D symmetric, A^T D - C^T B identity
    ok = ok && (a00 * c01 + a10 * c11 == a01 * c00 + a11 * c10);
    ok = ok && (b00 * d01 + b10 * d11 == b01 * d00 + b11 * d10);
    ok = ok && (a00 * d00 + a10 * d10 - c00 * b00 - c10 * b10 == 1);
    ok = ok && (a00 * d01 + a10 * d11 - c00 * b01 - c10 * b11 == 0);
    ok = ok && (a01 * d00 + a11 * d10 - c01 * b00 - c11 * b10 == 0);
    ok = ok && (a01 * d01 + a11 * d11 - c01 * b01 - c11 * b11 == 1);
    if (!ok) begin
      r.status = 1'b1;
      return r;
    end

    u0 = longint'(it.upper_one[0]);
    u1 = longint'(it.upper_two[0]);
    l0 = longint'(it.lower_one[0]);
    l1 = longint'(it.lower_two[0]);

    du0 = d00 * u0 + d01 * u1;
    du1 = d10 * u0 + d11 * u1;
    cl0 = c00 * l0 + c01 * l1;
    cl1 = c10 * l0 + c11 * l1;
    nu0 = du0 - cl0 + c00 * d00 + c01 * d01;
    nu1 = du1 - cl1 + c10 * d10 + c11 * d11;
    ab0 = a00 * b00 + a01 * b01;
    ab1 = a10 * b10 + a11 * b11;
    nl0 = a00 * l0 + a01 * l1 - (b00 * u0 + b01 * u1) + ab0;
    nl1 = a10 * l0 + a11 * l1 - (b10 * u0 + b11 * u1) + ab1;

    bd00 = b00 * d00 + b01 * d01;
    bd01 = b00 * d10 + b01 * d11;
    bd10 = b10 * d00 + b11 * d01;
    bd11 = b10 * d10 + b11 * d11;
    ac00 = a00 * c00 + a10 * c10;
    ac01 = a00 * c01 + a10 * c11;
    ac10 = a01 * c00 + a11 * c10;
    ac11 = a01 * c01 + a11 * c11;
    bc00 = b00 * c00 + b10 * c10;
    bc01 = b00 * c01 + b10 * c11;
    bc10 = b01 * c00 + b11 * c10;
    bc11 = b01 * c01 + b11 * c11;
    q1 = u0 * bd00 * u0 + u0 * bd01 * u1 + u1 * bd10 * u0 + u1 * bd11 * u1;
    q2 = l0 * ac00 * l0 + l0 * ac01 * l1 + l1 * ac10 * l0 + l1 * ac11 * l1;
    q3 = u0 * bc00 * l0 + u0 * bc01 * l1 + u1 * bc10 * l0 + u1 * bc11 * l1;
    ph = -4 * q1 + 8 * q2 - 16 * q3 - 8 * (ab0 * (du0 - cl0) + ab1 * (du1 - cl1));

    r.new_upper_one = nu0[0];
    r.new_upper_two = nu1[0];
    r.new_lower_one = nl0[0];
    r.new_lower_two = nl1[0];
    r.exponent      = ph[2:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = xform_result_t'(m_axis_tdata_i);
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, expected none actual %h", $time, got);
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("new_upper_one", want.new_upper_one, got.new_upper_one);
          check_field("new_upper_two", want.new_upper_two, got.new_upper_two);
          check_field("new_lower_one", want.new_lower_one, got.new_lower_one);
          check_field("new_lower_two", want.new_lower_two, got.new_lower_two);
          check_field("multiplier_exponent", want.exponent, got.exponent);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_q.push_back(predict_transform(xform_item_t'(s_axis_tdata_i)));
      end
      fail_count_o <= errors;
      pending_o    <= expected_q.size();
    end
  end

endmodule

[tb/tb_sp4_characteristic_transform_top.sv]
`timescale 1ns / 1ps
module tb_sp4_characteristic_transform_top;

  localparam int unsigned EntryBits   = 16;
  localparam int          RandomItems = 1800;
  localparam int          CycleLimit  = 400000;

  typedef enum logic [2:0] {
    GenUpper,
    GenLower,
    GenShear,
    GenSwap,
    GenTurn,
    GenFlip
  } gen_kind_e;

  typedef enum logic [1:0] {
    RxFree,
    RxMostly,
    RxSparse,
    RxPeriodic
  } rx_mode_e;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [sp4ct_pkg::InBits-1:0]  s_axis_tdata_i = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [sp4ct_pkg::OutBits-1:0] m_axis_tdata_o;

  int fail_count;
  int pending;

  longint mtx[4][4];
  longint gen_m[4][4];
  longint prod_m[4][4];

  int burst_left = 0;
  int cycle_count = 0;
  int n, sel, fld, w;
  logic [1:0] chr[4];
  logic [287:0] noise;

  rx_mode_e rx_mode = RxFree;
  int       rx_left = 0;
  int       rx_tick = 0;

  always #1 clk_i = ~clk_i;

  sp4_characteristic_transform_top #(
    .ENTRY_BITS(EntryBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  sp4_transform_checker #(
    .ENTRY_BITS(EntryBits)
  ) checker_u (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // receiver stalls
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RxFree: begin
        m_axis_tready_i <= 1'b1;
      end
      RxMostly: begin
        m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      end
      RxSparse: begin
        m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        m_axis_tready_i <= ((rx_tick % 5) < 2);
      end
    endcase
  end

  task automatic mtx_fill(input longint v);
    int i, j;
    for (i = 0; i < 4; i++) begin
      for (j = 0; j < 4; j++) begin
        mtx[i][j] = v;
      end
    end
  endtask

  task automatic mtx_identity();
    int i;
    mtx_fill(0);
    for (i = 0; i < 4; i++) begin
      mtx[i][i] = 1;
    end
  endtask

  function automatic longint pick_coef();
    logic [15:0] wide;
    wide = 16'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      return longint'($signed(wide));
    end
    return longint'($urandom_range(0, 6)) - 3;
  endfunction

  // right-multiply mtx by a symplectic generator, kept only if entries stay in 16 bits
  task automatic apply_gen(input gen_kind_e kind);
    longint s0, s1, s2, acc;
    bit     fits;
    int     i, j, k;
    s0 = pick_coef();
    s1 = pick_coef();
    s2 = pick_coef();
    for (i = 0; i < 4; i++) begin
      for (j = 0; j < 4; j++) begin
        gen_m[i][j] = (i == j) ? 1 : 0;
      end
    end
    case (kind)
      GenUpper: begin
        gen_m[0][2] = s0;
        gen_m[0][3] = s1;
        gen_m[1][2] = s1;
        gen_m[1][3] = s2;
      end
      GenLower: begin
        gen_m[2][0] = s0;
        gen_m[2][1] = s1;
        gen_m[3][0] = s1;
        gen_m[3][1] = s2;
      end
      GenShear: begin
        gen_m[0][1] = s0;
        gen_m[3][2] = -s0;
      end
      GenSwap: begin
        gen_m[0][0] = 0;
        gen_m[1][1] = 0;
        gen_m[2][2] = 0;
        gen_m[3][3] = 0;
        gen_m[0][1] = 1;
        gen_m[1][0] = 1;
        gen_m[2][3] = 1;
        gen_m[3][2] = 1;
      end
      GenTurn: begin
        for (i = 0; i < 4; i++) begin
          gen_m[i][i] = 0;
        end
        gen_m[0][2] = 1;
        gen_m[1][3] = 1;
        gen_m[2][0] = -1;
        gen_m[3][1] = -1;
      end
      default: begin
        gen_m[0][0] = -1;
        gen_m[2][2] = -1;
      end
    endcase
    fits = 1'b1;
    for (i = 0; i < 4; i++) begin
      for (j = 0; j < 4; j++) begin
        acc = 0;
        for (k = 0; k < 4; k++) begin
          acc = acc + mtx[i][k] * gen_m[k][j];
        end
        prod_m[i][j] = acc;
        if (acc > 32767 || acc < -32768) begin
          fits = 1'b0;
        end
      end
    end
    if (fits) begin
      for (i = 0; i < 4; i++) begin
        for (j = 0; j < 4; j++) begin
          mtx[i][j] = prod_m[i][j];
        end
      end
    end
  endtask

  function automatic logic [sp4ct_pkg::InBits-1:0] pack_mtx(
    input logic [1:0] ub1, input logic [1:0] ub2, input logic [1:0] lb1, input logic [1:0] lb2
  );
    logic [sp4ct_pkg::InBits-1:0] d;
    logic [63:0]                  e;
    int                           b, p;
    d = '0;
    for (b = 0; b < 4; b++) begin
      for (p = 0; p < 4; p++) begin
        e = mtx[(b >> 1) * 2 + (p >> 1)][(b & 1) * 2 + (p & 1)];
        d[64*b + 16*p +: 16] = e[15:0];
      end
    end
    d[257:256] = ub1;
    d[259:258] = ub2;
    d[261:260] = lb1;
    d[263:262] = lb2;
    return d;
  endfunction

  // one transfer, then maybe a gap before the next burst
  task automatic send_item(input logic [sp4ct_pkg::InBits-1:0] d);
    int gap;
    s_axis_tdata_i  <= d;
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("sp4_characteristic_transform_top verification failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    mtx_identity();
    send_item(pack_mtx(2'd0, 2'd0, 2'd0, 2'd0));
    send_item(pack_mtx(2'd1, 2'd1, 2'd1, 2'd1));
    send_item(pack_mtx(2'd1, 2'd0, 2'd0, 2'd1));
    apply_gen(GenTurn);
    send_item(pack_mtx(2'd1, 2'd0, 2'd1, 2'd0));
    send_item(pack_mtx(2'd0, 2'd1, 2'd1, 2'd1));
    send_item(pack_mtx(2'd3, 2'd3, 2'd3, 2'd3));
    mtx_fill(0);
    for (n = 0; n < 4; n++) begin
      mtx[n][n] = -1;
    end
    send_item(pack_mtx(2'd1, 2'd1, 2'd0, 2'd1));
    mtx_identity();
    mtx[0][2] = 32767;
    mtx[0][3] = -32768;
    mtx[1][2] = -32768;
    mtx[1][3] = -1;
    send_item(pack_mtx(2'd1, 2'd1, 2'd1, 2'd0));
    mtx_identity();
    mtx[2][0] = -32768;
    mtx[2][1] = 32767;
    mtx[3][0] = 32767;
    mtx[3][1] = 32767;
    send_item(pack_mtx(2'd1, 2'd1, 2'd1, 2'd1));
    mtx_identity();
    mtx[0][1] = 32767;
    mtx[3][2] = -32767;
    send_item(pack_mtx(2'd0, 2'd1, 2'd1, 2'd0));
    // invalid characteristic bits on a good matrix
    mtx_identity();
    for (fld = 0; fld < 4; fld++) begin
      for (w = 2; w < 4; w++) begin
        send_item(pack_mtx((fld == 0) ? 2'(w) : 2'd1, (fld == 1) ? 2'(w) : 2'd0,
                           (fld == 2) ? 2'(w) : 2'd1, (fld == 3) ? 2'(w) : 2'd0));
      end
    end
    // matrices that fail the block conditions
    mtx_fill(0);
    send_item(pack_mtx(2'd1, 2'd0, 2'd1, 2'd0));
    mtx_fill(-1);
    send_item(pack_mtx(2'd1, 2'd1, 2'd1, 2'd1));
    mtx_fill(-32768);
    send_item(pack_mtx(2'd0, 2'd1, 2'd0, 2'd1));
    mtx_fill(32767);
    send_item(pack_mtx(2'd1, 2'd0, 2'd0, 2'd1));
    mtx_identity();
    mtx[1][1] = 2;
    send_item(pack_mtx(2'd0, 2'd0, 2'd1, 2'd1));
    drain_results();

    // random
    for (n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) begin
        drain_results();
      end
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        for (w = 0; w < 9; w++) begin
          noise[32*w +: 32] = $urandom;
        end
        send_item(noise[sp4ct_pkg::InBits-1:0]);
      end else begin
        mtx_identity();
        repeat ($urandom_range(1, 6)) apply_gen(gen_kind_e'($urandom_range(0, 5)));
        for (fld = 0; fld < 4; fld++) begin
          chr[fld] = 2'($urandom_range(0, 1));
        end
        if (sel < 20) begin
          mtx[$urandom_range(0, 3)][$urandom_range(0, 3)] += ($urandom_range(0, 1) ? 1 : -1);
        end else if (sel < 30) begin
          chr[$urandom_range(0, 3)] = 2'($urandom_range(2, 3));
        end
        send_item(pack_mtx(chr[0], chr[1], chr[2], chr[3]));
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("sp4_characteristic_transform_top verification clean");
    end else begin
      $display("sp4_characteristic_transform_top verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/sp4ct_pkg.sv
sv/sp4ct_prod.sv
sv/sp4ct_sum.sv
sv/sp4ct_res.sv
sv/sp4_characteristic_transform_top.sv
tb/sp4_transform_checker.sv
tb/tb_sp4_characteristic_transform_top.sv
